@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and codes shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// item kinds on the byte stream
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// result kinds
	localparam logic [1:0] RK_BYTE  = 2'd0;
	localparam logic [1:0] RK_EMPTY = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	// length byte decoding
	localparam logic [7:0] LEN_MASK  = 8'h7F;
	localparam logic [6:0] LEN_EXT16 = 7'd126;

	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_LEN    = 3'd1,
		PH_EXT_HI = 3'd2,
		PH_EXT_LO = 3'd3,
		PH_DATA   = 3'd4
	} wsd_phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} wsd_in_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] payload_byte;
		logic       last_of_message;
	} wsd_out_t;

	// what the parser hands to the result register for one item
	typedef struct packed {
		logic     has_result;
		wsd_out_t res;
	} wsd_step_t;

endpackage

@@ hw/rtl/wsd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine: decodes one stream item against the parser
// state and updates that state when the item is consumed.
// ----------------------------------------------------------------------------
module wsd_parser
	import wsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  wsd_in_t   item,
	input  logic      consume,
	output wsd_step_t step
);

	wsd_phase_t  phase_q, phase_d;
	logic [15:0] remain_q, remain_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic        halted_q, halted_d;

	logic [6:0]  len7;
	logic [15:0] ext_len;
	logic [15:0] remain_dec;

	assign len7       = 7'(item.data_byte & LEN_MASK);
	assign ext_len    = {len_hi_q, item.data_byte};
	assign remain_dec = remain_q - 16'd1;

	// next state
	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		len_hi_d = len_hi_q;
		halted_d = halted_q;
		if (item.kind == KIND_RESTART) begin
			phase_d  = PH_HDR0;
			remain_d = '0;
			len_hi_d = '0;
			halted_d = 1'b0;
		end else if (!halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (len7 < LEN_EXT16) begin
						remain_d = {9'd0, len7};
						phase_d  = (len7 == 7'd0) ? PH_HDR0 : PH_DATA;
					end else if (len7 == LEN_EXT16) begin
						phase_d = PH_EXT_HI;
					end else begin
						halted_d = 1'b1;
						phase_d  = PH_HDR0;
						remain_d = '0;
					end
				end
				PH_EXT_HI: begin
					len_hi_d = item.data_byte;
					phase_d  = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					remain_d = ext_len;
					phase_d  = (ext_len == 16'd0) ? PH_HDR0 : PH_DATA;
				end
				PH_DATA: begin
					remain_d = remain_dec;
					if (remain_dec == 16'd0) begin
						phase_d = PH_HDR0;
					end
				end
				default: begin
					phase_d = PH_LEN;
				end
			endcase
		end
	end

	// result for this item
	always_comb begin
		step = '0;
		if (item.kind == KIND_BYTE && !halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					if (len7 == 7'd0) begin
						step.has_result          = 1'b1;
						step.res.result_kind     = RK_EMPTY;
						step.res.last_of_message = 1'b1;
					end else if (len7 > LEN_EXT16) begin
						step.has_result      = 1'b1;
						step.res.result_kind = RK_ERROR;
					end
				end
				PH_EXT_LO: begin
					if (ext_len == 16'd0) begin
						step.has_result          = 1'b1;
						step.res.result_kind     = RK_EMPTY;
						step.res.last_of_message = 1'b1;
					end
				end
				PH_DATA: begin
					step.has_result          = 1'b1;
					step.res.result_kind     = RK_BYTE;
					step.res.payload_byte    = item.data_byte;
					step.res.last_of_message = (remain_dec == 16'd0);
				end
				default: begin
					step.has_result = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			remain_q <= '0;
			len_hi_q <= '0;
			halted_q <= 1'b0;
		end else if (consume) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			len_hi_q <= len_hi_d;
			halted_q <= halted_d;
		end
	end

endmodule

@@ hw/rtl/wsd_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg
	import wsd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  wsd_step_t step,
	input  logic      load,
	output logic      room,
	output logic      result_valid,
	input  logic      result_stall,
	output wsd_out_t  result_item
);

	logic     valid_s2;
	wsd_out_t item_s2;

	// free when empty or being drained this cycle
	assign room = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load && step.has_result) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && step.has_result) begin
			item_s2 <= step.res;
		end
	end

	assign result_valid = valid_s2;
	assign result_item  = item_s2;

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: strips headers, passes payload bytes.
//
//   channel   direction  handshake                    payload
//   stream    in         stream_valid / stream_stall  wsd_in_t  (kind, byte)
//   result    out        result_valid / result_stall  wsd_out_t (kind, byte, last)
//
// One item per cycle sustained unless a result has nowhere to go. An item is
// registered on accept, decoded against the header state in the next cycle and
// its result, if any, is registered for the receiver in the result register.
// Reset clears the header state, the error flag and both stage valids.
// A stalled result holds only items that produce a result; others pass.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
	import wsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     stream_valid,
	output logic     stream_stall,
	input  wsd_in_t  stream_item,
	output logic     result_valid,
	input  logic     result_stall,
	output wsd_out_t result_item
);

	logic      valid_s1;
	wsd_in_t   item_s1;
	wsd_step_t step;
	logic      room;
	logic      advance;

	// move the held item on unless its result has nowhere to go
	assign advance      = valid_s1 && (!step.has_result || room);
	assign stream_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stream_stall) begin
			valid_s1 <= stream_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && !stream_stall) begin
			item_s1 <= stream_item;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.consume (advance),
		.step    (step)
	);

	wsd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.load         (advance),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

@@ hw/rtl/wsd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module wsd_checker
	import wsd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     stream_valid,
	input logic     stream_stall,
	input wsd_in_t  stream_item,
	input logic     result_valid,
	input logic     result_stall,
	input wsd_out_t result_item
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result changed");

	// empty message always closes a message and carries no byte
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.result_kind == RK_EMPTY |->
		result_item.last_of_message && result_item.payload_byte == 8'd0)
		else $error("malformed empty message");

	// error result carries no byte and no last mark
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.result_kind == RK_ERROR |->
		!result_item.last_of_message && result_item.payload_byte == 8'd0)
		else $error("malformed error result");

	// no result can appear without an item having been accepted before
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stream_valid && !stream_stall, 2) ||
		$past(stream_stall, 1))
		else $error("result without a prior item");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

@@ tb/websocket_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking bench for the receive-side WebSocket frame deframer.
// Drives byte and restart items with random gaps and random result stalls.
// Predicts every result from a behavioral copy of the header parser and
// compares each delivered result field by field, in order. Covers:
// short, extended and zero-length frames; the unsupported 64-bit length
// and the halted state; restarts mid-frame; long backpressure; one
// long extended-length frame.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
	import wsd_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned RANDOM_ITEMS = 800;

	logic     clk;
	logic     arst_n;
	logic     stream_valid;
	logic     stream_stall;
	wsd_in_t  stream_item;
	logic     result_valid;
	logic     result_stall;
	wsd_out_t result_item;

	websocket_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream_valid),
		.stream_stall (stream_stall),
		.stream_item  (stream_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// parser state as the block should hold it
	wsd_phase_t  hdr_phase     = PH_HDR0;
	logic [15:0] bytes_left    = '0;
	logic [7:0]  ext_len_high  = '0;
	bit          parser_halted = 1'b0;

	wsd_out_t    pending_results[$];

	int unsigned live_items;
	int unsigned frames_sent;
	int unsigned restarts_seen;
	int unsigned results_checked;
	int unsigned payload_bytes;
	int unsigned empty_msgs;
	int unsigned length_errors;
	int unsigned input_stall_cycles;
	int unsigned mismatches;
	int unsigned idle_cycles;

	bit          tx_quiet;
	bit          rx_quiet;
	int unsigned hold_len;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none while quiet
	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic void begin_payload(input logic [15:0] len);
		if (len == 16'd0) begin
			hdr_phase = PH_HDR0;
			bytes_left = '0;
			pending_results.push_back({RK_EMPTY, 8'h00, 1'b1});
		end else begin
			bytes_left = len;
			hdr_phase = PH_DATA;
		end
	endfunction

	// advance the parser by one accepted item and queue its result
	function automatic void deframe_step(input wsd_in_t it);
		logic [6:0] len7;
		if (it.kind == KIND_RESTART) begin
			hdr_phase = PH_HDR0;
			bytes_left = '0;
			ext_len_high = '0;
			parser_halted = 1'b0;
			restarts_seen++;
			return;
		end
		if (parser_halted)
			return;
		live_items++;
		case (hdr_phase)
			PH_LEN: begin
				len7 = 7'(it.data_byte & LEN_MASK);
				if (len7 < LEN_EXT16) begin
					begin_payload({9'd0, len7});
				end else if (len7 == LEN_EXT16) begin
					hdr_phase = PH_EXT_HI;
				end else begin
					parser_halted = 1'b1;
					hdr_phase = PH_HDR0;
					bytes_left = '0;
					pending_results.push_back({RK_ERROR, 8'h00, 1'b0});
				end
			end
			PH_EXT_HI: begin
				ext_len_high = it.data_byte;
				hdr_phase = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				begin_payload({ext_len_high, it.data_byte});
			end
			PH_DATA: begin
				bytes_left = bytes_left - 16'd1;
				if (bytes_left == 16'd0)
					hdr_phase = PH_HDR0;
				pending_results.push_back({RK_BYTE, it.data_byte, bytes_left == 16'd0});
			end
			default: begin
				hdr_phase = PH_LEN;
			end
		endcase
	endfunction

	function automatic void report_mismatch(input string what, input wsd_out_t exp_r,
			input wsd_out_t got_r);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected kind=%0d byte=%02h last=%0b,",
				$realtime, what, exp_r.result_kind, exp_r.payload_byte,
				exp_r.last_of_message,
				"  got kind=%0d byte=%02h last=%0b",
				got_r.result_kind, got_r.payload_byte, got_r.last_of_message);
	endfunction

	// check delivered results first, then predict from the accepted item
	always @(posedge clk) begin
		wsd_out_t exp_r;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", '0, result_item);
				end else begin
					exp_r = pending_results.pop_front();
					if (result_item.result_kind !== exp_r.result_kind
							|| result_item.payload_byte !== exp_r.payload_byte
							|| result_item.last_of_message !== exp_r.last_of_message)
						report_mismatch("result mismatch", exp_r, result_item);
					case (exp_r.result_kind)
						RK_BYTE:  payload_bytes++;
						RK_EMPTY: empty_msgs++;
						default:  length_errors++;
					endcase
				end
			end
			if (stream_valid && stream_stall)
				input_stall_cycles++;
			if (stream_valid && !stream_stall)
				deframe_step(stream_item);
		end
	end

	always @(posedge clk) begin
		if ((stream_valid && !stream_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("[%0t] watchdog: no item moved for %0d cycles, %0d results pending",
					$realtime, IDLE_LIMIT, pending_results.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		int unsigned n;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				result_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				result_stall <= 1'b0;
			end else begin
				n = pick_gap(rx_quiet);
				if (n != 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
					result_stall <= 1'b0;
				end
			end
		end
	end

	// leaves valid high when no gap follows, so the next item goes out back to back
	task automatic send_item(input logic kind, input logic [7:0] b);
		int unsigned gap;
		stream_item <= {kind, b};
		stream_valid <= 1'b1;
		do @(posedge clk); while (stream_stall);
		gap = pick_gap(tx_quiet);
		if (gap != 0) begin
			stream_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input int unsigned len, input bit ext);
		send_item(KIND_BYTE, 8'($urandom));
		if (ext) begin
			send_item(KIND_BYTE, {1'($urandom_range(0, 1)), LEN_EXT16});
			send_item(KIND_BYTE, len[15:8]);
			send_item(KIND_BYTE, len[7:0]);
		end else begin
			send_item(KIND_BYTE, {1'($urandom_range(0, 1)), len[6:0]});
		end
		repeat (len) send_item(KIND_BYTE, 8'($urandom));
		frames_sent++;
	endtask

	// hold the sender until every predicted result has been delivered
	task automatic wait_drained();
		stream_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		// zero length with mask bit set
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, 8'h80);
		// single byte frame
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'h01);
		send_item(KIND_BYTE, 8'hFF);
		// extended length of zero
		send_frame(0, 1'b1);
		// extended length of two
		send_item(KIND_BYTE, 8'h81);
		send_item(KIND_BYTE, 8'hFE);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'h02);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hA5);
		// unsupported length, bytes dropped while halted, then restart
		send_item(KIND_BYTE, 8'h82);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, 8'h81);
		send_item(KIND_BYTE, 8'h05);
		send_item(KIND_RESTART, 8'hFF);
		// restart in the middle of a payload
		send_item(KIND_BYTE, 8'h81);
		send_item(KIND_BYTE, 8'h05);
		send_item(KIND_BYTE, 8'h3C);
		send_item(KIND_BYTE, 8'hC3);
		send_item(KIND_RESTART, 8'h00);
		send_frame(1, 1'b0);
		wait_drained();
	endtask

	// receiver holds off long enough that the block must stall its input
	task automatic test_backpressure();
		tx_quiet = 1'b1;
		hold_len = 60;
		send_frame(40, 1'b0);
		send_frame(24, 1'b1);
		tx_quiet = 1'b0;
		wait_drained();
	endtask

	// sender pauses until everything is delivered between frames
	task automatic test_drain_pause();
		repeat (3) begin
			send_frame($urandom_range(0, 6), 1'b0);
			wait_drained();
		end
	endtask

	// extended length with a nonzero high byte, back to back on both sides
	task automatic test_long_frame();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		send_frame(16'h0123, 1'b1);
		send_frame(125, 1'b0);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_stream();
		int unsigned start_items;
		int unsigned r;
		int unsigned n;
		start_items = live_items;
		while (live_items - start_items < RANDOM_ITEMS) begin
			// switch idling on and off now and then
			if ($urandom_range(0, 19) == 0)
				tx_quiet = ~tx_quiet;
			if ($urandom_range(0, 19) == 0)
				rx_quiet = ~rx_quiet;
			if (parser_halted)
				send_item(KIND_RESTART, 8'($urandom));
			r = $urandom_range(0, 99);
			if (r < 80) begin
				n = $urandom_range(0, 99);
				if (n < 35)
					send_frame($urandom_range(0, 3), 1'b0);
				else if (n < 65)
					send_frame($urandom_range(4, 20), 1'b0);
				else if (n < 75)
					send_frame($urandom_range(21, 125), 1'b0);
				else if (n < 78)
					send_frame(125, 1'b0);
				else if (n < 92)
					send_frame($urandom_range(0, 12), 1'b1);
				else
					send_frame($urandom_range(126, 300), 1'b1);
			end else if (r < 88) begin
				send_item($urandom_range(0, 3) == 0 ? KIND_RESTART : KIND_BYTE,
					8'($urandom));
			end else if (r < 94) begin
				// unsupported length, some dropped bytes, restart
				send_item(KIND_BYTE, 8'($urandom));
				send_item(KIND_BYTE, {1'($urandom_range(0, 1)), 7'h7F});
				repeat ($urandom_range(0, 4)) send_item(KIND_BYTE, 8'($urandom));
				send_item(KIND_RESTART, 8'($urandom));
			end else begin
				// truncated frame cut off by a restart
				n = $urandom_range(2, 20);
				send_item(KIND_BYTE, 8'($urandom));
				send_item(KIND_BYTE, {1'($urandom_range(0, 1)), 7'(n)});
				repeat ($urandom_range(0, n - 1)) send_item(KIND_BYTE, 8'($urandom));
				send_item(KIND_RESTART, 8'($urandom));
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		stream_valid <= 1'b0;
		stream_item <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_drain_pause();
		test_long_frame();
		test_random_stream();
		wait_drained();

		$display("Covered %0d frames and %0d restarts; checked %0d results", frames_sent,
			restarts_seen, results_checked);
		$display("(%0d payload bytes, %0d empty messages, %0d length errors),",
			payload_bytes, empty_msgs, length_errors,
			" %0d stalled input cycles", input_stall_cycles);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results never delivered", mismatches,
				pending_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_out_reg.sv
hw/rtl/websocket_frame_deframer.sv
hw/rtl/wsd_checker.sv
tb/websocket_frame_deframer_tb.sv
